FILE: src/lcdnb_pkg.sv
`default_nettype none
package lcdnb_pkg;

	localparam int unsigned TICK_REG_W = 16;
	localparam int unsigned LINE_LEN_W = 6;
	localparam int unsigned ADDR_W     = 7;

	localparam logic [1:0] CFG_PULSE  = 2'd0;
	localparam logic [1:0] CFG_SETTLE = 2'd1;
	localparam logic [1:0] CFG_GAP    = 2'd2;
	localparam logic [1:0] CFG_LINE   = 2'd3;

	localparam logic [TICK_REG_W-1:0] PULSE_RESET  = 16'd50;
	localparam logic [TICK_REG_W-1:0] SETTLE_RESET = 16'd500;
	localparam logic [TICK_REG_W-1:0] GAP_RESET    = 16'd50000;
	localparam logic [LINE_LEN_W-1:0] LINE_RESET   = 6'd16;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_INSTR = 2'd1;
	localparam logic [1:0] MODE_CHAR  = 2'd2;
	localparam logic [1:0] MODE_INIT  = 2'd3;

	localparam logic [7:0] WRAP_TO_LINE2 = 8'hC0;
	localparam logic [7:0] WRAP_TO_LINE1 = 8'h80;
	localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
	localparam logic [3:0] MODE4_NIBBLE  = 4'h2;

	localparam logic [3:0] INIT_LAST_WAKE  = 4'd3;
	localparam logic [3:0] INIT_FIRST_INSTR = 4'd5;
	localparam logic [3:0] INIT_LAST_STEP  = 4'd10;
	localparam logic [3:0] INIT_START      = 4'd1;
	localparam logic [3:0] INIT_NONE       = 4'd0;

	typedef enum logic [13:0] {
		PH_IDLE    = 14'b00000000000001,
		PH_RD_HI_H = 14'b00000000000010,
		PH_RD_HI_L = 14'b00000000000100,
		PH_RD_LO_H = 14'b00000000001000,
		PH_RD_LO_L = 14'b00000000010000,
		PH_BSETTLE = 14'b00000000100000,
		PH_WR_HI_H = 14'b00000001000000,
		PH_WR_HI_L = 14'b00000010000000,
		PH_WR_LO_H = 14'b00000100000000,
		PH_WR_LO_L = 14'b00001000000000,
		PH_ISETTLE = 14'b00010000000000,
		PH_IN_H    = 14'b00100000000000,
		PH_IN_L    = 14'b01000000000000,
		PH_IN_GAP  = 14'b10000000000000
	} phase_t;

	typedef enum logic [1:0] {
		DUR_PULSE,
		DUR_SETTLE,
		DUR_GAP
	} dur_sel_t;

	typedef enum logic [2:0] {
		NIB_ZERO,
		NIB_HIGH,
		NIB_LOW,
		NIB_WAKE,
		NIB_MODE4
	} nib_sel_t;

	typedef struct packed {
		logic       cnt_clr;
		logic       cnt_inc;
		logic       load_cmd;
		logic       load_init;
		logic [2:0] init_sel;
		logic       sample_hi;
		logic       sample_lo;
		logic       latch_addr;
		logic       set_wrap;
		logic       wrap_active;
		dur_sel_t   dur_sel;
		logic       pin_e;
		logic       pin_rs;
		logic       pin_rw;
		logic       drive;
		logic       rdy;
		nib_sel_t   nib_sel;
	} lcdnb_cmd_t;

	typedef struct packed {
		logic tick_done;
		logic busy_bit;
		logic addr_end1;
		logic addr_end2;
	} lcdnb_stat_t;

	function automatic logic [7:0] init_instr(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = 8'h28;
			3'd1:    r = 8'h08;
			3'd2:    r = 8'h06;
			3'd3:    r = 8'h17;
			3'd4:    r = 8'h01;
			3'd5:    r = 8'h02;
			3'd6:    r = 8'h0F;
			default: r = 8'h28;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/char_lcd_nibble_bus_controller.sv
// each accepted tick gives one result, registered and shown the cycle after the transfer
// one tick per clock while results are taken; the result register frees as it is read
// pulse, settle and gap lengths count ticks, not clocks
// asynchronous reset: idle, timing registers at their defaults, result register empty
`default_nettype none
module char_lcd_nibble_bus_controller #(
	parameter int unsigned DELAY_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  cmd_byte,
	input  wire logic [3:0]  bus_nibble_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             pin_e,
	output logic             pin_rs,
	output logic             pin_rw,
	output logic [3:0]       data_out,
	output logic             data_drive,
	output logic             ready_res,
	output logic [6:0]       cursor_address,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	lcdnb_pkg::lcdnb_cmd_t  cmd;
	lcdnb_pkg::lcdnb_stat_t stat;
	logic                   step;

	assign in_ready = !out_valid || out_ready;
	assign step     = in_valid && in_ready;

	lcdnb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd)
	);

	lcdnb_dp #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.out_ready      (out_ready),
		.cmd_byte       (cmd_byte),
		.bus_nibble_in  (bus_nibble_in),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.pin_e          (pin_e),
		.pin_rs         (pin_rs),
		.pin_rw         (pin_rw),
		.data_out       (data_out),
		.data_drive     (data_drive),
		.ready_res      (ready_res),
		.cursor_address (cursor_address)
	);

endmodule
`default_nettype wire

FILE: src/lcdnb_ctrl.sv
`default_nettype none
module lcdnb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [1:0]          mode,
	input  wire lcdnb_pkg::lcdnb_stat_t stat,
	output lcdnb_pkg::lcdnb_cmd_t    cmd
);

	lcdnb_pkg::phase_t phase_q, phase_d;
	logic [3:0] init_q, init_d;
	logic       wrap_q, wrap_d;
	logic       char_q, char_d;
	logic       wr_char;
	logic [3:0] init_off;

	assign wr_char  = char_q && !wrap_q;
	assign init_off = init_q - 4'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lcdnb_pkg::PH_IDLE;
			init_q  <= lcdnb_pkg::INIT_NONE;
			wrap_q  <= 1'b0;
			char_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			init_q  <= init_d;
			wrap_q  <= wrap_d;
			char_q  <= char_d;
		end
	end

	// pin levels for the current tick, and the next phase on each accepted tick
	always_comb begin
		cmd             = '0;
		cmd.dur_sel     = lcdnb_pkg::DUR_PULSE;
		cmd.nib_sel     = lcdnb_pkg::NIB_ZERO;
		cmd.wrap_active = wrap_q;
		case (phase_q)
			lcdnb_pkg::PH_IDLE: cmd.rdy = 1'b1;
			lcdnb_pkg::PH_RD_HI_H, lcdnb_pkg::PH_RD_LO_H: begin
				cmd.pin_e  = 1'b1;
				cmd.pin_rw = 1'b1;
			end
			lcdnb_pkg::PH_RD_HI_L, lcdnb_pkg::PH_RD_LO_L: cmd.pin_rw = 1'b1;
			lcdnb_pkg::PH_BSETTLE: begin
				cmd.pin_rw  = 1'b1;
				cmd.dur_sel = lcdnb_pkg::DUR_SETTLE;
			end
			lcdnb_pkg::PH_WR_HI_H, lcdnb_pkg::PH_WR_HI_L,
			lcdnb_pkg::PH_WR_LO_H, lcdnb_pkg::PH_WR_LO_L: begin
				cmd.pin_e   = (phase_q == lcdnb_pkg::PH_WR_HI_H) ||
				              (phase_q == lcdnb_pkg::PH_WR_LO_H);
				cmd.pin_rs  = wr_char;
				cmd.drive   = 1'b1;
				cmd.nib_sel = ((phase_q == lcdnb_pkg::PH_WR_HI_H) ||
				               (phase_q == lcdnb_pkg::PH_WR_HI_L)) ?
				              lcdnb_pkg::NIB_HIGH : lcdnb_pkg::NIB_LOW;
			end
			lcdnb_pkg::PH_ISETTLE: cmd.dur_sel = lcdnb_pkg::DUR_SETTLE;
			lcdnb_pkg::PH_IN_H, lcdnb_pkg::PH_IN_L: begin
				cmd.pin_e   = (phase_q == lcdnb_pkg::PH_IN_H);
				cmd.drive   = 1'b1;
				cmd.nib_sel = (init_q <= lcdnb_pkg::INIT_LAST_WAKE) ?
				              lcdnb_pkg::NIB_WAKE : lcdnb_pkg::NIB_MODE4;
			end
			lcdnb_pkg::PH_IN_GAP: cmd.dur_sel = lcdnb_pkg::DUR_GAP;
			default: cmd.rdy = 1'b1;
		endcase

		phase_d = phase_q;
		init_d  = init_q;
		wrap_d  = wrap_q;
		char_d  = char_q;

		if (step) begin
			if (phase_q == lcdnb_pkg::PH_IDLE) begin
				if (mode == lcdnb_pkg::MODE_INSTR || mode == lcdnb_pkg::MODE_CHAR) begin
					char_d       = (mode == lcdnb_pkg::MODE_CHAR);
					wrap_d       = 1'b0;
					init_d       = lcdnb_pkg::INIT_NONE;
					cmd.load_cmd = 1'b1;
					cmd.cnt_clr  = 1'b1;
					phase_d      = lcdnb_pkg::PH_RD_HI_H;
				end else if (mode == lcdnb_pkg::MODE_INIT) begin
					char_d      = 1'b0;
					wrap_d      = 1'b0;
					init_d      = lcdnb_pkg::INIT_START;
					cmd.cnt_clr = 1'b1;
					phase_d     = lcdnb_pkg::PH_IN_H;
				end
			end else if (!stat.tick_done) begin
				cmd.cnt_inc = 1'b1;
			end else begin
				cmd.cnt_clr = 1'b1;
				case (phase_q)
					lcdnb_pkg::PH_RD_HI_H: begin
						cmd.sample_hi = 1'b1;
						phase_d       = lcdnb_pkg::PH_RD_HI_L;
					end
					lcdnb_pkg::PH_RD_HI_L: phase_d = lcdnb_pkg::PH_RD_LO_H;
					lcdnb_pkg::PH_RD_LO_H: begin
						cmd.sample_lo = 1'b1;
						phase_d       = lcdnb_pkg::PH_RD_LO_L;
					end
					lcdnb_pkg::PH_RD_LO_L: begin
						if (stat.busy_bit) begin
							phase_d = lcdnb_pkg::PH_RD_HI_H;
						end else begin
							cmd.latch_addr = 1'b1;
							phase_d        = lcdnb_pkg::PH_BSETTLE;
						end
					end
					lcdnb_pkg::PH_BSETTLE: begin
						// cursor at a line end: move it before the character
						if (wr_char && (stat.addr_end1 || stat.addr_end2)) begin
							cmd.set_wrap = 1'b1;
							wrap_d       = 1'b1;
							phase_d      = lcdnb_pkg::PH_RD_HI_H;
						end else begin
							phase_d = lcdnb_pkg::PH_WR_HI_H;
						end
					end
					lcdnb_pkg::PH_WR_HI_H: phase_d = lcdnb_pkg::PH_WR_HI_L;
					lcdnb_pkg::PH_WR_HI_L: phase_d = lcdnb_pkg::PH_WR_LO_H;
					lcdnb_pkg::PH_WR_LO_H: phase_d = lcdnb_pkg::PH_WR_LO_L;
					lcdnb_pkg::PH_WR_LO_L:
						phase_d = wr_char ? lcdnb_pkg::PH_IDLE : lcdnb_pkg::PH_ISETTLE;
					lcdnb_pkg::PH_ISETTLE: begin
						if (wrap_q) begin
							wrap_d  = 1'b0;
							phase_d = lcdnb_pkg::PH_WR_HI_H;
						end else if (init_q inside {[lcdnb_pkg::INIT_FIRST_INSTR :
						                              lcdnb_pkg::INIT_LAST_STEP]}) begin
							init_d        = init_q + 4'd1;
							cmd.load_init = 1'b1;
							cmd.init_sel  = init_off[2:0];
							phase_d       = lcdnb_pkg::PH_RD_HI_H;
						end else begin
							init_d  = lcdnb_pkg::INIT_NONE;
							phase_d = lcdnb_pkg::PH_IDLE;
						end
					end
					lcdnb_pkg::PH_IN_H: phase_d = lcdnb_pkg::PH_IN_L;
					lcdnb_pkg::PH_IN_L: begin
						if (init_q <= lcdnb_pkg::INIT_LAST_WAKE) begin
							phase_d = lcdnb_pkg::PH_IN_GAP;
						end else begin
							init_d        = lcdnb_pkg::INIT_FIRST_INSTR;
							char_d        = 1'b0;
							cmd.load_init = 1'b1;
							cmd.init_sel  = 3'd0;
							phase_d       = lcdnb_pkg::PH_RD_HI_H;
						end
					end
					lcdnb_pkg::PH_IN_GAP: begin
						init_d  = init_q + 4'd1;
						phase_d = lcdnb_pkg::PH_IN_H;
					end
					default: phase_d = lcdnb_pkg::PH_IDLE;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/lcdnb_dp.sv
`default_nettype none
module lcdnb_dp #(
	parameter int unsigned DELAY_WIDTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic                out_ready,
	input  wire logic [7:0]          cmd_byte,
	input  wire logic [3:0]          bus_nibble_in,
	input  wire logic                cfg_wr_en,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	input  wire lcdnb_pkg::lcdnb_cmd_t cmd,
	output lcdnb_pkg::lcdnb_stat_t   stat,
	output logic                     out_valid,
	output logic                     pin_e,
	output logic                     pin_rs,
	output logic                     pin_rw,
	output logic [3:0]               data_out,
	output logic                     data_drive,
	output logic                     ready_res,
	output logic [6:0]               cursor_address
);

	localparam int unsigned RW = lcdnb_pkg::TICK_REG_W;

	logic [RW-1:0]          pulse_q, settle_q, gap_q;
	logic [5:0]             line_q;
	logic [DELAY_WIDTH-1:0] tick_q;
	logic [7:0]             status_q, pending_q, wrap_cmd_q;
	logic [6:0]             addr_q;
	logic                   valid_q;
	logic                   e_q, rs_q, rw_q, drive_q, rdy_q;
	logic [3:0]             dout_q;

	logic [RW-1:0]          dur_raw, raw_m1;
	logic [DELAY_WIDTH-1:0] dur_m1;
	logic [7:0]             send_byte;
	logic [3:0]             nib;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q  <= lcdnb_pkg::PULSE_RESET;
			settle_q <= lcdnb_pkg::SETTLE_RESET;
			gap_q    <= lcdnb_pkg::GAP_RESET;
			line_q   <= lcdnb_pkg::LINE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lcdnb_pkg::CFG_PULSE:  pulse_q  <= cfg_data;
				lcdnb_pkg::CFG_SETTLE: settle_q <= cfg_data;
				lcdnb_pkg::CFG_GAP:    gap_q    <= cfg_data;
				lcdnb_pkg::CFG_LINE:   line_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.dur_sel)
			lcdnb_pkg::DUR_SETTLE: dur_raw = settle_q;
			lcdnb_pkg::DUR_GAP:    dur_raw = gap_q;
			default:               dur_raw = pulse_q;
		endcase
	end

	// zero counts as one tick
	assign raw_m1 = (dur_raw == '0) ? '0 : dur_raw - RW'(1);

	generate
		if (DELAY_WIDTH > RW) begin : g_wide
			assign dur_m1 = {{(DELAY_WIDTH-RW){1'b0}}, raw_m1};
		end else if (DELAY_WIDTH == RW) begin : g_same
			assign dur_m1 = raw_m1;
		end else begin : g_narrow
			// clip long durations to the counter range
			assign dur_m1 = (|raw_m1[RW-1:DELAY_WIDTH]) ? '1 : raw_m1[DELAY_WIDTH-1:0];
		end
	endgenerate

	assign stat.tick_done = (tick_q == dur_m1);
	assign stat.busy_bit  = status_q[7];
	assign stat.addr_end1 = (addr_q == {1'b0, line_q});
	assign stat.addr_end2 = (addr_q == {1'b1, line_q});

	assign send_byte = cmd.wrap_active ? wrap_cmd_q : pending_q;

	always_comb begin
		case (cmd.nib_sel)
			lcdnb_pkg::NIB_HIGH:  nib = send_byte[7:4];
			lcdnb_pkg::NIB_LOW:   nib = send_byte[3:0];
			lcdnb_pkg::NIB_WAKE:  nib = lcdnb_pkg::WAKE_NIBBLE;
			lcdnb_pkg::NIB_MODE4: nib = lcdnb_pkg::MODE4_NIBBLE;
			default:              nib = 4'h0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			status_q   <= '0;
			pending_q  <= '0;
			wrap_cmd_q <= '0;
			addr_q     <= '0;
		end else if (step) begin
			if (cmd.cnt_clr) begin
				tick_q <= '0;
			end else if (cmd.cnt_inc) begin
				tick_q <= tick_q + DELAY_WIDTH'(1);
			end
			if (cmd.sample_hi) begin
				status_q[7:4] <= bus_nibble_in;
			end
			if (cmd.sample_lo) begin
				status_q[3:0] <= bus_nibble_in;
			end
			if (cmd.latch_addr) begin
				addr_q <= status_q[6:0];
			end
			if (cmd.load_cmd) begin
				pending_q <= cmd_byte;
			end else if (cmd.load_init) begin
				pending_q <= lcdnb_pkg::init_instr(cmd.init_sel);
			end
			if (cmd.set_wrap) begin
				wrap_cmd_q <= stat.addr_end1 ? lcdnb_pkg::WRAP_TO_LINE2 :
				                               lcdnb_pkg::WRAP_TO_LINE1;
			end
		end
	end

	// result register, refilled on every transfer in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			e_q     <= cmd.pin_e;
			rs_q    <= cmd.pin_rs;
			rw_q    <= cmd.pin_rw;
			drive_q <= cmd.drive;
			rdy_q   <= cmd.rdy;
			dout_q  <= nib;
		end
	end

	// address is read before the step updates it
	logic [6:0] addr_out_q;
	always_ff @(posedge clk) begin
		if (step) begin
			addr_out_q <= addr_q;
		end
	end

	assign out_valid      = valid_q;
	assign pin_e          = e_q;
	assign pin_rs         = rs_q;
	assign pin_rw         = rw_q;
	assign data_out       = dout_q;
	assign data_drive     = drive_q;
	assign ready_res      = rdy_q;
	assign cursor_address = addr_out_q;

endmodule
`default_nettype wire
